@@ hw/rtl/bnv_pkg.sv @@
// ----------------------------------------------------------------------------
// Bucket name validator package
// Shared constants, types and character class functions.
// ----------------------------------------------------------------------------
package bnv_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned GROUP_CNT_W = 3;
  localparam int unsigned GROUP_DIG_W = 2;
  localparam int unsigned GROUP_VAL_W = 10;

  localparam logic [LEN_W-1:0]       LEN_MAX         = 8'd255;
  localparam logic [LEN_W-1:0]       MIN_LENGTH_RST  = 8'd3;
  localparam logic [LEN_W-1:0]       MAX_LENGTH_RST  = 8'd63;
  localparam logic [GROUP_CNT_W-1:0] GROUP_CNT_SAT   = 3'd5;
  localparam logic [GROUP_CNT_W-1:0] GROUP_CNT_QUAD  = 3'd4;
  localparam logic [GROUP_DIG_W-1:0] GROUP_DIG_MAX   = 2'd3;
  localparam logic [GROUP_VAL_W-1:0] GROUP_VAL_LIMIT = 10'd255;

  localparam logic [CHAR_W-1:0] CH_PERIOD = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MIN_LENGTH = 2'd0,
    CFG_MAX_LENGTH = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [LEN_W-1:0] min_length;
    logic [LEN_W-1:0] max_length;
  } limits_t;

  typedef struct packed {
    logic name_ok;
    logic bad_length;
    logic bad_first;
    logic bad_last;
    logic double_period;
    logic dash_by_period;
    logic bad_symbol;
    logic looks_like_ip;
  } verdict_t;

  function automatic logic is_lower(input logic [CHAR_W-1:0] c);
    return (c >= CH_LOW_A) && (c <= CH_LOW_Z);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alnum_low(input logic [CHAR_W-1:0] c);
    return is_lower(c) || is_digit(c);
  endfunction

endpackage

@@ hw/rtl/bnv_ifs.sv @@
// ----------------------------------------------------------------------------
// Bucket name validator stream interfaces
// Character input channel and verdict output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bnv_char_if;
  logic                        valid;
  logic                        ready;
  logic [bnv_pkg::CHAR_W-1:0]  char_code;
  logic                        last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface bnv_verdict_if;
  logic valid;
  logic ready;
  logic name_ok;
  logic bad_length;
  logic bad_first;
  logic bad_last;
  logic double_period;
  logic dash_by_period;
  logic bad_symbol;
  logic looks_like_ip;

  modport source (
    output valid, output name_ok, output bad_length, output bad_first,
    output bad_last, output double_period, output dash_by_period,
    output bad_symbol, output looks_like_ip, input ready
  );
  modport sink (
    input valid, input name_ok, input bad_length, input bad_first,
    input bad_last, input double_period, input dash_by_period,
    input bad_symbol, input looks_like_ip, output ready
  );
endinterface

@@ hw/rtl/bnv_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Bucket name validator configuration registers
// Holds the minimum and maximum name length limits.
// ----------------------------------------------------------------------------
module bnv_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bnv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bnv_pkg::CFG_DATA_W-1:0]    cfg_data,
  output bnv_pkg::limits_t                  limits
);

  bnv_pkg::limits_t limits_next;

  always_comb begin
    limits_next = limits;
    if (cfg_we) begin
      unique case (bnv_pkg::cfg_index_t'(cfg_index))
        bnv_pkg::CFG_MIN_LENGTH: limits_next.min_length = cfg_data[bnv_pkg::LEN_W-1:0];
        bnv_pkg::CFG_MAX_LENGTH: limits_next.max_length = cfg_data[bnv_pkg::LEN_W-1:0];
        default: limits_next = limits;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.min_length <= bnv_pkg::MIN_LENGTH_RST;
      limits.max_length <= bnv_pkg::MAX_LENGTH_RST;
    end else begin
      limits <= limits_next;
    end
  end

endmodule

@@ hw/rtl/bnv_scan.sv @@
// ----------------------------------------------------------------------------
// Bucket name validator character scanner
// Running per-name state and the verdict formed at the last character.
// ----------------------------------------------------------------------------
module bnv_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [bnv_pkg::CHAR_W-1:0]    char_code,
  input  logic                          last_char,
  input  bnv_pkg::limits_t              limits,
  output bnv_pkg::verdict_t             verdict
);

  logic [bnv_pkg::LEN_W-1:0]        length_count, length_count_next;
  logic [bnv_pkg::CHAR_W-1:0]       previous_char;
  logic                             first_error, first_error_next;
  logic [2:0]                       pair_errors, pair_errors_next;
  logic [bnv_pkg::GROUP_CNT_W-1:0]  group_count, group_count_next;
  logic [bnv_pkg::GROUP_DIG_W-1:0]  group_digits, group_digits_next;
  logic [bnv_pkg::GROUP_VAL_W-1:0]  group_value, group_value_next;
  logic                             ip_possible, ip_possible_next;

  logic c_period, c_dash, c_digit, c_alnum;
  logic [bnv_pkg::GROUP_VAL_W-1:0] digit_value;

  assign c_period    = (char_code == bnv_pkg::CH_PERIOD);
  assign c_dash      = (char_code == bnv_pkg::CH_DASH);
  assign c_digit     = bnv_pkg::is_digit(char_code);
  assign c_alnum     = bnv_pkg::is_alnum_low(char_code);
  assign digit_value = {{(bnv_pkg::GROUP_VAL_W-4){1'b0}}, char_code[3:0]};

  always_comb begin
    first_error_next  = first_error;
    pair_errors_next  = pair_errors;
    length_count_next = length_count;
    group_count_next  = group_count;
    group_digits_next = group_digits;
    group_value_next  = group_value;
    ip_possible_next  = ip_possible;

    if (length_count == '0 && !c_alnum) begin
      first_error_next = 1'b1;
    end
    if (length_count != '0) begin
      if (previous_char == bnv_pkg::CH_PERIOD && c_period) begin
        pair_errors_next[0] = 1'b1;
      end
      if ((previous_char == bnv_pkg::CH_PERIOD && c_dash) ||
          (previous_char == bnv_pkg::CH_DASH && c_period)) begin
        pair_errors_next[1] = 1'b1;
      end
    end
    if (!(c_alnum || c_dash || c_period)) begin
      pair_errors_next[2] = 1'b1;
    end
    if (length_count != bnv_pkg::LEN_MAX) begin
      length_count_next = length_count + 1'b1;
    end

    if (c_period) begin
      group_digits_next = '0;
      group_value_next  = '0;
    end else if (c_digit) begin
      if (group_digits == '0) begin
        if (group_count != bnv_pkg::GROUP_CNT_SAT) begin
          group_count_next = group_count + 1'b1;
        end
        if (group_count_next > bnv_pkg::GROUP_CNT_QUAD) begin
          ip_possible_next = 1'b0;
        end
      end
      if (group_digits == bnv_pkg::GROUP_DIG_MAX) begin
        ip_possible_next = 1'b0;
      end else begin
        group_digits_next = group_digits + 1'b1;
        // At most two digits are held here, so the value stays below 100.
        group_value_next  = (group_value << 3) + (group_value << 1) + digit_value;
        if (group_value_next > bnv_pkg::GROUP_VAL_LIMIT) begin
          ip_possible_next = 1'b0;
        end
      end
    end else begin
      ip_possible_next = 1'b0;
    end
  end

  always_comb begin
    verdict.bad_length     = (length_count_next < limits.min_length) ||
                             (length_count_next > limits.max_length);
    verdict.bad_first      = first_error_next;
    verdict.bad_last       = !c_alnum;
    verdict.double_period  = pair_errors_next[0];
    verdict.dash_by_period = pair_errors_next[1];
    verdict.bad_symbol     = pair_errors_next[2];
    verdict.looks_like_ip  = ip_possible_next && (group_count_next == bnv_pkg::GROUP_CNT_QUAD);
    verdict.name_ok        = !(verdict.bad_length | verdict.bad_first | verdict.bad_last |
                               verdict.double_period | verdict.dash_by_period |
                               verdict.bad_symbol | verdict.looks_like_ip);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_char)) begin
      length_count  <= '0;
      previous_char <= '0;
      first_error   <= 1'b0;
      pair_errors   <= '0;
      group_count   <= '0;
      group_digits  <= '0;
      group_value   <= '0;
      ip_possible   <= 1'b1;
    end else if (step) begin
      length_count  <= length_count_next;
      previous_char <= char_code;
      first_error   <= first_error_next;
      pair_errors   <= pair_errors_next;
      group_count   <= group_count_next;
      group_digits  <= group_digits_next;
      group_value   <= group_value_next;
      ip_possible   <= ip_possible_next;
    end
  end

endmodule

@@ hw/rtl/bucket_name_validator_core.sv @@
// ----------------------------------------------------------------------------
// Bucket name validator core
// Checks a bucket name streamed one character per transfer and delivers
// one verdict transfer for the transfer that carries the last character.
//
//   Channel   Direction  Handshake     Payload
//   in_ch     sink       valid/ready   char_code[7:0], last_char
//   out_ch    source     valid/ready   name_ok and seven rule flags
//   cfg       write      cfg_we        cfg_index[1:0], cfg_data[7:0]
//
// One character is taken every cycle unless a last character waits in the input
// register for out_ch; the verdict comes from the input and result registers.
// Reset is synchronous and restores the default limits of 3 and 63.
// While a verdict waits on out_ch, further characters are still accepted
// until the next last character reaches the input register.
// ----------------------------------------------------------------------------
module bucket_name_validator_core (
  input  logic                             clk,
  input  logic                             rst,
  bnv_char_if.sink                         in_ch,
  bnv_verdict_if.source                    out_ch,
  input  logic                             cfg_we,
  input  logic [bnv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bnv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  bnv_pkg::limits_t  limits;
  bnv_pkg::verdict_t verdict;
  bnv_pkg::verdict_t out_data;

  logic                        s1_valid;
  logic [bnv_pkg::CHAR_W-1:0]  s1_char;
  logic                        s1_last;
  logic                        out_valid;
  logic                        out_free;
  logic                        s1_adv;
  logic                        in_take;

  bnv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  bnv_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_adv),
    .char_code (s1_char),
    .last_char (s1_last),
    .limits    (limits),
    .verdict   (verdict)
  );

  assign out_free    = !out_valid || out_ch.ready;
  assign s1_adv      = s1_valid && (!s1_last || out_free);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char <= in_ch.char_code;
      s1_last <= in_ch.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      out_data <= verdict;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.name_ok        = out_data.name_ok;
  assign out_ch.bad_length     = out_data.bad_length;
  assign out_ch.bad_first      = out_data.bad_first;
  assign out_ch.bad_last       = out_data.bad_last;
  assign out_ch.double_period  = out_data.double_period;
  assign out_ch.dash_by_period = out_data.dash_by_period;
  assign out_ch.bad_symbol     = out_data.bad_symbol;
  assign out_ch.looks_like_ip  = out_data.looks_like_ip;

endmodule

@@ sim/bucket_name_validator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket name validator checker
// Watches the character and verdict channels and the limit register writes,
// keeps its own copy of the name-checking state, and compares every verdict
// transfer with the oldest predicted verdict, flag by flag.
// ----------------------------------------------------------------------------
module bucket_name_validator_checker (
  input  logic                             clk,
  input  logic                             rst,
  bnv_char_if                              in_ch,
  bnv_verdict_if                           out_ch,
  input  logic                             cfg_we,
  input  logic [bnv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bnv_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fail_count,
  output int                               pending,
  output int                               verdict_count
);
  import bnv_pkg::*;

  logic [LEN_W-1:0]       min_len;
  logic [LEN_W-1:0]       max_len;
  logic [LEN_W-1:0]       name_len;
  logic [CHAR_W-1:0]      prev_char;
  logic                   first_bad;
  logic                   saw_double;
  logic                   saw_dash_pair;
  logic                   saw_symbol;
  logic [GROUP_CNT_W-1:0] groups;
  logic [GROUP_DIG_W-1:0] digits;
  logic [GROUP_VAL_W-1:0] value;
  logic                   quad_shape;
  verdict_t               verdict_queue[$];

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return c >= 8'h61 && c <= 8'h7A;
  endfunction

  function automatic logic is_numeral(input logic [CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_edge_char(input logic [CHAR_W-1:0] c);
    return is_letter(c) || is_numeral(c);
  endfunction

  task automatic restart_name();
    name_len      = '0;
    prev_char     = '0;
    first_bad     = 1'b0;
    saw_double    = 1'b0;
    saw_dash_pair = 1'b0;
    saw_symbol    = 1'b0;
    groups        = '0;
    digits        = '0;
    value         = '0;
    quad_shape    = 1'b1;
  endtask

  task automatic absorb_char(input logic [CHAR_W-1:0] c, input logic last);
    verdict_t v;
    if (name_len == 0 && !is_edge_char(c)) first_bad = 1'b1;
    if (name_len != 0) begin
      if (prev_char == CH_PERIOD && c == CH_PERIOD) saw_double = 1'b1;
      if ((prev_char == CH_PERIOD && c == CH_DASH) || (prev_char == CH_DASH && c == CH_PERIOD))
        saw_dash_pair = 1'b1;
    end
    if (!(is_edge_char(c) || c == CH_DASH || c == CH_PERIOD)) saw_symbol = 1'b1;
    if (name_len != LEN_MAX) name_len = name_len + 1'b1;

    if (c == CH_PERIOD) begin
      digits = '0;
      value  = '0;
    end else if (is_numeral(c)) begin
      if (digits == 0) begin
        if (groups < GROUP_CNT_SAT) groups = groups + 1'b1;
        if (groups > GROUP_CNT_QUAD) quad_shape = 1'b0;
      end
      if (digits >= GROUP_DIG_MAX) begin
        quad_shape = 1'b0;
      end else begin
        digits = digits + 1'b1;
        value  = GROUP_VAL_W'(value * 10 + (c - CH_ZERO));
        if (value > GROUP_VAL_LIMIT) quad_shape = 1'b0;
      end
    end else begin
      quad_shape = 1'b0;
    end
    prev_char = c;

    if (last) begin
      v.bad_length     = (name_len < min_len) || (name_len > max_len);
      v.bad_first      = first_bad;
      v.bad_last       = !is_edge_char(c);
      v.double_period  = saw_double;
      v.dash_by_period = saw_dash_pair;
      v.bad_symbol     = saw_symbol;
      v.looks_like_ip  = quad_shape && (groups == GROUP_CNT_QUAD);
      v.name_ok        = !(v.bad_length || v.bad_first || v.bad_last || v.double_period ||
                           v.dash_by_period || v.bad_symbol || v.looks_like_ip);
      verdict_queue.push_back(v);
      restart_name();
    end
  endtask

  task automatic check_flag(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      min_len = MIN_LENGTH_RST;
      max_len = MAX_LENGTH_RST;
      restart_name();
      verdict_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_LENGTH: min_len = cfg_data;
          CFG_MAX_LENGTH: max_len = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_queue.size() == 0) begin
          $error("verdict transfer with no name pending");
          fail_count++;
        end else begin
          want = verdict_queue.pop_front();
          verdict_count++;
          check_flag("name_ok", want.name_ok, out_ch.name_ok);
          check_flag("bad_length", want.bad_length, out_ch.bad_length);
          check_flag("bad_first", want.bad_first, out_ch.bad_first);
          check_flag("bad_last", want.bad_last, out_ch.bad_last);
          check_flag("double_period", want.double_period, out_ch.double_period);
          check_flag("dash_by_period", want.dash_by_period, out_ch.dash_by_period);
          check_flag("bad_symbol", want.bad_symbol, out_ch.bad_symbol);
          check_flag("looks_like_ip", want.looks_like_ip, out_ch.looks_like_ip);
        end
      end
      if (in_ch.valid && in_ch.ready) absorb_char(in_ch.char_code, in_ch.last_char);
    end
    pending = verdict_queue.size();
  end

endmodule

@@ sim/bucket_name_validator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket name validator core testbench
// Streams directed and random bucket names through the core under several
// length limit settings, with random stalls on both channels, and lets the
// checker predict and compare every verdict transfer.
// ----------------------------------------------------------------------------
module bucket_name_validator_core_tb;
  import bnv_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int TARGET_CHARS      = 1750;
  localparam int CHARS_PER_SETTING = 250;
  localparam int SETTLE_CYCLES     = 4;
  localparam int NUM_SETTINGS      = 7;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending;
  int                     verdict_count;
  int                     send_idle_pct;
  int                     recv_idle_pct;
  int                     chars_sent;
  int                     names_sent;
  logic [CHAR_W-1:0]      name_chars[$];
  logic [LEN_W-1:0]       min_set[NUM_SETTINGS];
  logic [LEN_W-1:0]       max_set[NUM_SETTINGS];

  bnv_char_if    char_ch();
  bnv_verdict_if verdict_ch();

  bucket_name_validator_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (char_ch),
    .out_ch    (verdict_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bucket_name_validator_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (char_ch),
    .out_ch        (verdict_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .verdict_count (verdict_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    verdict_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #1_000_000;
    $display("bucket_name_validator_core: mismatch");
    $finish;
  end

  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      char_ch.valid <= 1'b0;
      @(posedge clk);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= c;
    char_ch.last_char <= last;
    do @(posedge clk); while (!char_ch.ready);
    chars_sent++;
  endtask

  task automatic send_name();
    if (chars_sent < TARGET_CHARS / 3) begin
      send_idle_pct = 31;
      recv_idle_pct = 76;
    end else if (chars_sent < 2 * TARGET_CHARS / 3) begin
      send_idle_pct = 76;
      recv_idle_pct = 31;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    foreach (name_chars[i]) send_char(name_chars[i], i == name_chars.size() - 1);
    names_sent++;
  endtask

  task automatic load_text(input string s);
    name_chars.delete();
    for (int i = 0; i < s.len(); i++) name_chars.push_back(s[i]);
  endtask

  task automatic drain_verdicts();
    char_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limits(input logic [LEN_W-1:0] lo, input logic [LEN_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_LENGTH;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX_LENGTH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= $urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3;
    cfg_data  <= CFG_DATA_W'($urandom_range(255));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int kind;
    int len;
    int ngroups;
    int ndig;
    int stop_at;
    int r;
    logic [CHAR_W-1:0] c;

    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = CFG_MIN_LENGTH;
    cfg_data           = '0;
    char_ch.valid      = 1'b0;
    char_ch.char_code  = '0;
    char_ch.last_char  = 1'b0;
    send_idle_pct      = 31;
    recv_idle_pct      = 76;
    chars_sent         = 0;
    names_sent         = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Short name, doubled period, both dash and period pairs, a leading-zero
    // dotted quad, and a name of stray symbols including codes 0 and 255.
    load_text("a");
    send_name();
    load_text("a..b");
    send_name();
    load_text("a.-b-.c");
    send_name();
    load_text("9.007.255.1");
    send_name();
    name_chars = '{CH_DASH, 8'h00, 8'hFF, CH_PERIOD};
    send_name();

    min_set = '{8'd1, 8'd0, 8'd255, 8'd40, 8'd1, 8'd0, MIN_LENGTH_RST};
    max_set = '{8'd254, 8'd255, 8'd254, 8'd10, 8'd1, 8'd0, MAX_LENGTH_RST};
    min_set[5] = LEN_W'($urandom_range(1, 20));
    max_set[5] = LEN_W'($urandom_range(5, 70));

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain_verdicts();
      write_limits(min_set[p], max_set[p]);
      stop_at = chars_sent + CHARS_PER_SETTING;
      while (chars_sent < stop_at) begin
        name_chars.delete();
        kind = $urandom_range(99);
        if (kind < 55) begin
          r = $urandom_range(99);
          if (r < 88) len = $urandom_range(1, 16);
          else if (r < 97) len = $urandom_range(17, 70);
          else if (r < 99) len = $urandom_range(230, 300);
          else len = $urandom_range(253, 256);
          repeat (len) begin
            r = $urandom_range(99);
            if (r < 62) c = CH_LOW_A + CHAR_W'($urandom_range(25));
            else if (r < 82) c = CH_ZERO + CHAR_W'($urandom_range(9));
            else if (r < 90) c = CH_DASH;
            else if (r < 98) c = CH_PERIOD;
            else c = CHAR_W'($urandom_range(255));
            name_chars.push_back(c);
          end
        end else if (kind < 80) begin
          ngroups = ($urandom_range(3) == 0) ? $urandom_range(3, 5) : 4;
          if ($urandom_range(9) == 0) name_chars.push_back(CH_PERIOD);
          for (int g = 0; g < ngroups; g++) begin
            if (g > 0) begin
              name_chars.push_back(CH_PERIOD);
              if ($urandom_range(9) == 0) name_chars.push_back(CH_PERIOD);
            end
            ndig = ($urandom_range(9) == 0) ? 4 : $urandom_range(1, 3);
            for (int d = 0; d < ndig; d++) begin
              if (d == 0 && ndig == 3) c = CH_ZERO + CHAR_W'($urandom_range(2));
              else c = CH_ZERO + CHAR_W'($urandom_range(9));
              name_chars.push_back(c);
            end
            if ($urandom_range(19) == 0) begin
              c = CH_LOW_A + CHAR_W'($urandom_range(25));
              name_chars.push_back(c);
            end
          end
          if ($urandom_range(9) == 0) name_chars.push_back(CH_PERIOD);
        end else if (kind < 92) begin
          repeat ($urandom_range(1, 12)) begin
            c = CHAR_W'($urandom_range(255));
            name_chars.push_back(c);
          end
        end else begin
          repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(3))
              0: c = CH_LOW_A;
              1: c = CH_ZERO + 8'd1;
              2: c = CH_PERIOD;
              default: c = CH_DASH;
            endcase
            name_chars.push_back(c);
          end
        end
        send_name();
        if ($urandom_range(24) == 0) drain_verdicts();
      end
    end

    drain_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d names; %0d verdicts were compared.",
             chars_sent, names_sent, verdict_count);
    $display("Length limits went through %0d settings, zero, inverted and widest bounds included.",
             NUM_SETTINGS + 1);
    if (fail_count == 0) begin
      $display("bucket_name_validator_core: match");
    end else begin
      $display("bucket_name_validator_core: mismatch");
    end
    $finish;
  end

endmodule
